/* hw/rtl/fimap_pkg.sv */
// Shared types, constants and codes for the fingerprint index table.
package fimap_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_SLOTS     = 8;
  localparam int KEY_BYTES     = 20;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = $clog2(MAX_SLOTS);
  localparam int KEY_W         = 8 * KEY_BYTES;
  localparam int ID_W          = 63;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [3:0] ST_HIT        = 4'd0;
  localparam logic [3:0] ST_MISS       = 4'd1;
  localparam logic [3:0] ST_UPDATED    = 4'd2;
  localparam logic [3:0] ST_INSERTED   = 4'd3;
  localparam logic [3:0] ST_FULL       = 4'd4;
  localparam logic [3:0] ST_REMOVED    = 4'd5;
  localparam logic [3:0] ST_ERASED     = 4'd6;
  localparam logic [3:0] ST_KEY_ABSENT = 4'd7;
  localparam logic [3:0] ST_ID_ABSENT  = 4'd8;

  localparam logic CFG_SLOTS_IN_USE = 1'b0;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [31:0] key_word2;
    logic [62:0] item_id;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot_index;
    logic [62:0] slot_id;
    logic        slot_empty;
    logic        last;
  } rsp_t;

endpackage

/* hw/rtl/fingerprint_index_fifo_map_core.sv */
// Fingerprint index table: key scan, slot read-modify-write and result sequencing.
// The key scan compares one table entry per cycle across all TABLE_ENTRIES; a miss, absent key
// or full table then gives a single result; an update or delete reads and rewrites the slot row first; a
// lookup hit then gives one result per cycle for slots_in_use results, held to 1..MAX_SLOTS.
// Throughput: one command at a time; start is taken again in the cycle of its last result.
// Reset (rst, synchronous): valid bits clear in a pass over all TABLE_ENTRIES with busy high;
// slots_in_use returns to 1. Results cannot be stalled.
module fingerprint_index_fifo_map_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  fimap_pkg::cmd_t      cmd,
  output logic                 done,
  output fimap_pkg::rsp_t      rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_SLOT_WAIT, S_APPLY, S_EMIT
  } state_t;

  typedef logic [fimap_pkg::MAX_SLOTS-1:0][63:0] row_t;

  state_t state;
  logic [3:0] slots_in_use;

  // latched command
  logic [1:0]                    op;
  logic [fimap_pkg::KEY_W-1:0]   key;
  logic [fimap_pkg::ID_W-1:0]    id;

  // key memory: valid bit on top of the stored key
  logic [fimap_pkg::KEY_W:0]     key_mem [fimap_pkg::TABLE_ENTRIES];
  logic [fimap_pkg::KEY_W:0]     key_q;
  logic [fimap_pkg::IDX_W-1:0]   scan_idx;
  logic                          issue;
  logic [fimap_pkg::IDX_W-1:0]   cmp_idx;
  logic                          cmp_vld;
  logic                          hit_f;
  logic                          free_f;
  logic [fimap_pkg::IDX_W-1:0]   hit_idx;
  logic [fimap_pkg::IDX_W-1:0]   free_idx;
  logic                          key_we;
  logic [fimap_pkg::IDX_W-1:0]   key_wa;
  logic [fimap_pkg::KEY_W:0]     key_wd;

  // slot memory: one row of all slots per entry
  row_t                          slot_mem [fimap_pkg::TABLE_ENTRIES];
  row_t                          slot_q;
  logic [fimap_pkg::IDX_W-1:0]   tgt;
  logic                          new_key;
  logic                          slot_we;
  row_t                          slot_wd;

  logic [fimap_pkg::SLOT_W-1:0]  cnt;
  logic [fimap_pkg::SLOT_W-1:0]  len_m1;
  logic [3:0]                    len;

  // modify results
  row_t                          base;
  row_t                          upd_row;
  row_t                          del_row;
  logic                          del_found;
  logic [fimap_pkg::SLOT_W-1:0]  del_pos;
  logic                          del_erase;
  logic [3:0]                    del_status;

  // single result of a command: status only, marked last
  function automatic fimap_pkg::rsp_t done_rsp(input logic [3:0] code);
    fimap_pkg::rsp_t r;
    r        = '0;
    r.status = code;
    r.last   = 1'b1;
    return r;
  endfunction

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = {28'd0, slots_in_use};

  always_comb begin
    if (slots_in_use == 4'd0) begin
      len = 4'd1;
    end else if (slots_in_use > 4'(fimap_pkg::MAX_SLOTS)) begin
      len = 4'(fimap_pkg::MAX_SLOTS);
    end else begin
      len = slots_in_use;
    end
    len_m1 = fimap_pkg::SLOT_W'(len - 4'd1);
  end

  always_comb begin
    base = new_key ? '0 : slot_q;
    // push at slot 0, shift the used slots down
    for (int i = 0; i < fimap_pkg::MAX_SLOTS; i++) begin
      if (i == 0) begin
        upd_row[i] = {1'b1, id};
      end else if (i < int'(len)) begin
        upd_row[i] = base[i-1];
      end else begin
        upd_row[i] = base[i];
      end
    end
    del_found = 1'b0;
    del_pos   = '0;
    for (int i = 0; i < fimap_pkg::MAX_SLOTS; i++) begin
      if (!del_found && i < int'(len) && slot_q[i][63] && slot_q[i][62:0] == id) begin
        del_found = 1'b1;
        del_pos   = fimap_pkg::SLOT_W'(i);
      end
    end
    // close the gap and clear the last used slot
    for (int j = 0; j < fimap_pkg::MAX_SLOTS; j++) begin
      if (del_found && j >= int'(del_pos) && j < int'(len)) begin
        if (j + 1 < int'(len)) begin
          del_row[j] = slot_q[(j + 1) % fimap_pkg::MAX_SLOTS];
        end else begin
          del_row[j] = '0;
        end
      end else begin
        del_row[j] = slot_q[j];
      end
    end
    del_erase  = !del_row[0][63];
    del_status = del_erase ? fimap_pkg::ST_ERASED :
                 (del_found ? fimap_pkg::ST_REMOVED : fimap_pkg::ST_ID_ABSENT);
  end

  always_comb begin
    key_we  = 1'b0;
    key_wa  = scan_idx;
    key_wd  = '0;
    slot_we = 1'b0;
    slot_wd = upd_row;
    if (state == S_CLEAR) begin
      key_we = 1'b1;
    end else if (state == S_APPLY) begin
      key_wa = tgt;
      if (op == fimap_pkg::OP_UPDATE) begin
        key_we  = new_key;
        key_wd  = {1'b1, key};
        slot_we = 1'b1;
      end else if (op == fimap_pkg::OP_DELETE) begin
        key_we  = del_erase;
        key_wd  = {1'b0, key};
        slot_we = 1'b1;
        slot_wd = del_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_q <= key_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[tgt] <= slot_wd;
    end
    slot_q <= slot_mem[tgt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= 4'd1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == fimap_pkg::CFG_SLOTS_IN_USE) begin
      slots_in_use <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      scan_idx <= '0;
      issue    <= 1'b0;
      cmp_vld  <= 1'b0;
      hit_f    <= 1'b0;
      free_f   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == fimap_pkg::IDX_W'(fimap_pkg::TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && cmd.op != fimap_pkg::OP_NONE) begin
            op       <= cmd.op;
            key      <= {cmd.key_word2, cmd.key_word1, cmd.key_word0};
            id       <= cmd.item_id;
            scan_idx <= '0;
            issue    <= 1'b1;
            cmp_vld  <= 1'b0;
            hit_f    <= 1'b0;
            free_f   <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
            if (scan_idx == fimap_pkg::IDX_W'(fimap_pkg::TABLE_ENTRIES - 1)) begin
              issue <= 1'b0;
            end
          end
          cmp_vld <= issue;
          cmp_idx <= scan_idx;
          if (cmp_vld) begin
            if (key_q[fimap_pkg::KEY_W]) begin
              if (!hit_f && key_q[fimap_pkg::KEY_W-1:0] == key) begin
                hit_f   <= 1'b1;
                hit_idx <= cmp_idx;
              end
            end else if (!free_f) begin
              free_f   <= 1'b1;
              free_idx <= cmp_idx;
            end
            if (cmp_idx == fimap_pkg::IDX_W'(fimap_pkg::TABLE_ENTRIES - 1)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          tgt     <= hit_f ? hit_idx : free_idx;
          new_key <= !hit_f;
          if (!hit_f && op == fimap_pkg::OP_LOOKUP) begin
            rsp   <= done_rsp(fimap_pkg::ST_MISS);
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (!hit_f && op == fimap_pkg::OP_DELETE) begin
            rsp   <= done_rsp(fimap_pkg::ST_KEY_ABSENT);
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (!hit_f && !free_f) begin
            rsp   <= done_rsp(fimap_pkg::ST_FULL);
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SLOT_WAIT;
          end
        end
        S_SLOT_WAIT: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          cnt <= '0;
          if (op == fimap_pkg::OP_LOOKUP) begin
            state <= S_EMIT;
          end else begin
            rsp   <= done_rsp((op == fimap_pkg::OP_UPDATE) ?
                               (new_key ? fimap_pkg::ST_INSERTED : fimap_pkg::ST_UPDATED) :
                               del_status);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          rsp  <= '{status:     fimap_pkg::ST_HIT,
                    slot_index: 3'(cnt),
                    slot_id:    slot_q[cnt][63] ? slot_q[cnt][62:0] : '0,
                    slot_empty: !slot_q[cnt][63],
                    last:       (cnt == len_m1)};
          done <= 1'b1;
          cnt  <= cnt + 1'b1;
          if (cnt == len_m1) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a real command always starts work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.op != fimap_pkg::OP_NONE) |=> busy)
    else $error("command transfer did not start work");

  // a lookup burst is contiguous until its last result
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.last) |=> done)
    else $error("result burst broken before last");

  // no result while the table is being cleared
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !done)
    else $error("result during clearing pass");
`endif

endmodule

/* sim/testbench.sv */
// Testbench for fingerprint_index_fifo_map_core: directed table and random traffic.
`timescale 1ns / 1ps

module testbench;

  localparam int SETTLE = fimap_pkg::TABLE_ENTRIES + 40;

  typedef struct {
    bit              cfg;
    logic [3:0]      cfg_val;
    fimap_pkg::cmd_t c;
    bit              want;
    logic [3:0]      st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  fimap_pkg::cmd_t cmd = '0;
  logic        done;
  fimap_pkg::rsp_t rsp;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // table shadow
  bit          ent_valid [fimap_pkg::TABLE_ENTRIES];
  logic [fimap_pkg::KEY_W-1:0] ent_key [fimap_pkg::TABLE_ENTRIES];
  logic [63:0] ent_slot [fimap_pkg::TABLE_ENTRIES][fimap_pkg::MAX_SLOTS];
  logic [3:0]  slots_reg;

  fimap_pkg::rsp_t expected_rsp [$];
  row_t        dir_rows [$];
  logic [63:0] key_pool [6][3];
  int          errors = 0;
  int          burst_left = 0;

  fingerprint_index_fifo_map_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic table_reset();
    foreach (ent_valid[e]) ent_valid[e] = 1'b0;
    slots_reg = 4'd1;
  endtask

  task automatic index_cmd(input fimap_pkg::cmd_t c);
    int hit, free_e, n, i, j;
    bit found;
    fimap_pkg::rsp_t r;
    logic [fimap_pkg::KEY_W-1:0] k;
    k = {c.key_word2, c.key_word1, c.key_word0};
    if (c.op == fimap_pkg::OP_NONE) return;
    hit = -1;
    free_e = -1;
    for (int e = 0; e < fimap_pkg::TABLE_ENTRIES; e++) begin
      if (ent_valid[e]) begin
        if (hit < 0 && ent_key[e] == k) hit = e;
      end else if (free_e < 0) begin
        free_e = e;
      end
    end
    n = (slots_reg == 0) ? 1 :
        ((slots_reg > fimap_pkg::MAX_SLOTS) ? fimap_pkg::MAX_SLOTS : int'(slots_reg));
    r = '0;
    r.last = 1'b1;
    case (c.op)
      fimap_pkg::OP_LOOKUP: begin
        if (hit < 0) begin
          r.status = fimap_pkg::ST_MISS;
          expected_rsp.push_back(r);
        end else begin
          for (i = 0; i < n; i++) begin
            r.status = fimap_pkg::ST_HIT;
            r.slot_index = 3'(i);
            r.slot_empty = !ent_slot[hit][i][63];
            r.slot_id = ent_slot[hit][i][63] ? ent_slot[hit][i][62:0] : '0;
            r.last = (i == n - 1);
            expected_rsp.push_back(r);
          end
        end
      end
      fimap_pkg::OP_UPDATE: begin
        r.status = fimap_pkg::ST_UPDATED;
        if (hit < 0) begin
          if (free_e < 0) begin
            r.status = fimap_pkg::ST_FULL;
            expected_rsp.push_back(r);
            return;
          end
          hit = free_e;
          ent_valid[hit] = 1'b1;
          ent_key[hit] = k;
          for (i = 0; i < fimap_pkg::MAX_SLOTS; i++) ent_slot[hit][i] = '0;
          r.status = fimap_pkg::ST_INSERTED;
        end
        for (i = n - 1; i > 0; i--) ent_slot[hit][i] = ent_slot[hit][i-1];
        ent_slot[hit][0] = {1'b1, c.item_id};
        expected_rsp.push_back(r);
      end
      default: begin
        if (hit < 0) begin
          r.status = fimap_pkg::ST_KEY_ABSENT;
        end else begin
          found = 1'b0;
          for (i = 0; i < n && !found; i++) begin
            if (ent_slot[hit][i][63] && ent_slot[hit][i][62:0] == c.item_id) begin
              for (j = i; j + 1 < n; j++) ent_slot[hit][j] = ent_slot[hit][j+1];
              ent_slot[hit][n-1] = '0;
              found = 1'b1;
            end
          end
          r.status = found ? fimap_pkg::ST_REMOVED : fimap_pkg::ST_ID_ABSENT;
          if (!ent_slot[hit][0][63]) begin
            ent_valid[hit] = 1'b0;
            r.status = fimap_pkg::ST_ERASED;
          end
        end
        expected_rsp.push_back(r);
      end
    endcase
  endtask

  // hold start high across back-to-back transfers; drop it only for a gap
  task automatic send_cmd(input fimap_pkg::cmd_t c);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      if ($urandom_range(0, 2) != 0) begin
        start = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
    burst_left--;
    cmd = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    index_cmd(c);
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_slots(input logic [3:0] v);
    drain();
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {fimap_pkg::CFG_SLOTS_IN_USE, 2'b00};
    pwdata = {$urandom} & 32'hFFFF_FFF0 | v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    slots_reg = v;
  endtask

  task automatic add_row(input logic [1:0] op, input int kid, input logic [62:0] id,
                         input bit want, input logic [3:0] st);
    row_t r;
    r.cfg = 1'b0;
    r.cfg_val = '0;
    r.c.op = op;
    r.c.key_word0 = key_pool[kid][0];
    r.c.key_word1 = key_pool[kid][1];
    r.c.key_word2 = key_pool[kid][2][31:0];
    r.c.item_id = id;
    r.want = want;
    r.st = st;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(input logic [3:0] v);
    row_t r;
    r = '{default: '0};
    r.cfg = 1'b1;
    r.cfg_val = v;
    dir_rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report($sformatf("unexpected result status %0d", rsp.status));
      end else begin
        fimap_pkg::rsp_t x;
        x = expected_rsp.pop_front();
        if (rsp.status !== x.status)
          report($sformatf("status %0d, want %0d", rsp.status, x.status));
        if (rsp.slot_index !== x.slot_index)
          report($sformatf("slot_index %0d, want %0d", rsp.slot_index, x.slot_index));
        if (rsp.slot_id !== x.slot_id)
          report($sformatf("slot_id %h, want %h", rsp.slot_id, x.slot_id));
        if (rsp.slot_empty !== x.slot_empty)
          report($sformatf("slot_empty %b, want %b", rsp.slot_empty, x.slot_empty));
        if (rsp.last !== x.last)
          report($sformatf("last %b, want %b", rsp.last, x.last));
      end
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL fingerprint_index_fifo_map_core");
    $finish;
  end

  initial begin
    fimap_pkg::cmd_t c;
    int kid;
    logic [62:0] id_max;
    table_reset();
    id_max = 63'h7FFF_FFFF_FFFF_FFFE;
    key_pool[0] = '{64'h0, 64'h0, 64'h0};
    key_pool[1] = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF};
    for (int p = 2; p < 6; p++)
      for (int w = 0; w < 3; w++) key_pool[p][w] = {$urandom, $urandom};
    // slots_in_use is 1 out of reset
    add_row(fimap_pkg::OP_LOOKUP, 0, '0, 1, fimap_pkg::ST_MISS);
    add_row(fimap_pkg::OP_DELETE, 0, '0, 1, fimap_pkg::ST_KEY_ABSENT);
    add_row(fimap_pkg::OP_UPDATE, 0, id_max, 1, fimap_pkg::ST_INSERTED);
    add_row(fimap_pkg::OP_UPDATE, 0, '0, 1, fimap_pkg::ST_UPDATED);
    add_row(fimap_pkg::OP_LOOKUP, 0, '0, 0, '0);
    add_row(fimap_pkg::OP_NONE, 0, '0, 0, '0);
    add_row(fimap_pkg::OP_DELETE, 0, 63'd5, 1, fimap_pkg::ST_ID_ABSENT);
    add_cfg(4'd8);
    add_row(fimap_pkg::OP_UPDATE, 1, 63'd1, 1, fimap_pkg::ST_INSERTED);
    add_row(fimap_pkg::OP_UPDATE, 1, 63'd2, 1, fimap_pkg::ST_UPDATED);
    add_row(fimap_pkg::OP_UPDATE, 1, 63'd3, 1, fimap_pkg::ST_UPDATED);
    add_row(fimap_pkg::OP_LOOKUP, 1, '0, 0, '0);
    add_row(fimap_pkg::OP_DELETE, 1, 63'd2, 1, fimap_pkg::ST_REMOVED);
    add_row(fimap_pkg::OP_LOOKUP, 1, '0, 0, '0);
    add_row(fimap_pkg::OP_DELETE, 1, 63'd3, 1, fimap_pkg::ST_REMOVED);
    add_row(fimap_pkg::OP_DELETE, 1, 63'd1, 1, fimap_pkg::ST_ERASED);
    add_row(fimap_pkg::OP_LOOKUP, 1, '0, 1, fimap_pkg::ST_MISS);
    add_cfg(4'd0);
    add_row(fimap_pkg::OP_UPDATE, 2, id_max, 1, fimap_pkg::ST_INSERTED);
    add_row(fimap_pkg::OP_LOOKUP, 2, '0, 0, '0);
    add_cfg(4'd15);
    add_row(fimap_pkg::OP_UPDATE, 2, 63'd9, 1, fimap_pkg::ST_UPDATED);
    add_row(fimap_pkg::OP_LOOKUP, 2, '0, 0, '0);
    // removing the only ID leaves slot 0 empty, so the key goes
    add_row(fimap_pkg::OP_DELETE, 0, '0, 1, fimap_pkg::ST_ERASED);
    add_row(fimap_pkg::OP_LOOKUP, 0, '0, 0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        write_slots(dir_rows[i].cfg_val);
      end else begin
        send_cmd(dir_rows[i].c);
        if (dir_rows[i].want && dir_rows[i].c.op != fimap_pkg::OP_NONE)
          expected_rsp[$].status = dir_rows[i].st;
      end
    end

    for (int n = 0; n < 250; n++) begin
      if (n % 50 == 25) write_slots(4'($urandom_range(0, 15)));
      if (n == 120) drain();
      kid = $urandom_range(0, 5);
      c.key_word0 = key_pool[kid][0];
      c.key_word1 = key_pool[kid][1];
      c.key_word2 = key_pool[kid][2][31:0];
      if ($urandom_range(0, 9) == 0) c.key_word0 = {$urandom, $urandom};
      c.item_id = ($urandom_range(0, 4) == 0) ? 63'({$urandom, $urandom}) :
                                                63'($urandom_range(0, 7));
      case ($urandom_range(0, 19))
        0:                     c.op = fimap_pkg::OP_NONE;
        1, 2, 3, 4, 5, 6:      c.op = fimap_pkg::OP_LOOKUP;
        7, 8, 9, 10:           c.op = fimap_pkg::OP_DELETE;
        default:               c.op = fimap_pkg::OP_UPDATE;
      endcase
      send_cmd(c);
    end

    start = 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("PASS fingerprint_index_fifo_map_core");
    end else begin
      $display("FAIL fingerprint_index_fifo_map_core");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fimap_pkg.sv
hw/rtl/fingerprint_index_fifo_map_core.sv
sim/testbench.sv
